// ===== rtl/core/ntc_table_interpolator_core_assert.svh =====
// Assertion macros shared by the thermistor interpolator RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef NTC_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define NTC_TABLE_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntc assertion failed");

// Next-cycle implication, checked outside reset.
`define NTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntc assertion failed");

`endif

// ===== rtl/core/ntc_pkg.sv =====
// Shared types, constants and table functions for the thermistor interpolator.
// No dependencies.
package ntc_pkg;

  localparam int HELD_POINTS = 34;
  localparam int IDX_W       = 6;
  localparam int CENTI       = 100;
  localparam int SEG_SPAN    = 5 * CENTI;   // centi-degrees between two points
  localparam int RES_W       = 18;
  localparam int TEMP_W      = 16;
  localparam int SPAN_W      = 16;          // widest ohm step of one segment
  localparam int DIV_W       = 27;          // dividend / quotient width
  localparam int CNT_W       = $clog2(DIV_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_PREP,
    B_DIV,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic                     kind;
    logic                     miss;
    idx_t                     seg;
    logic [RES_W-1:0]         resistance;
    logic signed [TEMP_W-1:0] temperature;
  } q_entry_t;

  function automatic logic [RES_W-1:0] ntc_ohm(input idx_t idx);
    logic [RES_W-1:0] r;
    unique case (idx)
      6'd0:  r = 18'd195652;
      6'd1:  r = 18'd148171;
      6'd2:  r = 18'd113347;
      6'd3:  r = 18'd87559;
      6'd4:  r = 18'd68237;
      6'd5:  r = 18'd53650;
      6'd6:  r = 18'd42506;
      6'd7:  r = 18'd33892;
      6'd8:  r = 18'd27219;
      6'd9:  r = 18'd22021;
      6'd10: r = 18'd17926;
      6'd11: r = 18'd14674;
      6'd12: r = 18'd12081;
      6'd13: r = 18'd10000;
      6'd14: r = 18'd8315;
      6'd15: r = 18'd6948;
      6'd16: r = 18'd5834;
      6'd17: r = 18'd4917;
      6'd18: r = 18'd4161;
      6'd19: r = 18'd3535;
      6'd20: r = 18'd3014;
      6'd21: r = 18'd2586;
      6'd22: r = 18'd2228;
      6'd23: r = 18'd1925;
      6'd24: r = 18'd1669;
      6'd25: r = 18'd1452;
      6'd26: r = 18'd1268;
      6'd27: r = 18'd1110;
      6'd28: r = 18'd974;
      6'd29: r = 18'd858;
      6'd30: r = 18'd758;
      6'd31: r = 18'd672;
      6'd32: r = 18'd596;
      6'd33: r = 18'd531;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Points sit every 5 degrees starting at -40 C.
  function automatic logic signed [TEMP_W-1:0] ntc_centi(input idx_t idx);
    int d;
    d = int'(idx) * SEG_SPAN - 40 * CENTI;
    return TEMP_W'(d);
  endfunction

endpackage

// ===== rtl/core/ntc_table_interpolator_core.sv =====
// NTC thermistor table interpolator, top level.
// Converts ohms to centi-degrees (kind 0) or centi-degrees to ohms (kind 1)
// by linear interpolation over a constant table, -40 C to 125 C in 5 C steps.
// Input channel: in_valid / in_stall with in_kind, in_resistance_in and
// in_temperature_in; a request is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with out_temperature_out,
// out_resistance_out and out_status; a result moves when out_valid is high and
// out_stall low. Every request yields exactly one result, in order.
// Out-of-table values return status 1 with both outputs zero.
// The front scans one segment per cycle, holding in_stall high from the accepted
// request until its entry has been pushed into the queue.
// On a hit the back multiplies, prepares and runs 27 divider steps before it
// writes the output; on a miss it goes straight to the output. A two-entry
// queue parts the two, so the sustained rate is set by the slower side.
// While out_stall is high the result is held, the back waits with its next
// answer, and the front keeps searching until the queue fills.
// Synchronous reset (rst_n low) empties the queue and clears out_valid.
module ntc_table_interpolator_core #(
  parameter int TABLE_POINTS = 34
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [ntc_pkg::RES_W-1:0]         in_resistance_in,
  input  logic signed [ntc_pkg::TEMP_W-1:0] in_temperature_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ntc_pkg::TEMP_W-1:0] out_temperature_out,
  output logic [ntc_pkg::RES_W-1:0]         out_resistance_out,
  output logic                              out_status
);

  logic              push, full, pop, empty;
  ntc_pkg::q_entry_t push_data, pop_data;

  ntc_front #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_resistance_in  (in_resistance_in),
    .in_temperature_in (in_temperature_in),
    .push              (push),
    .push_data         (push_data),
    .full              (full)
  );

  ntc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ntc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .empty               (empty),
    .pop_data            (pop_data),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_temperature_out (out_temperature_out),
    .out_resistance_out  (out_resistance_out),
    .out_status          (out_status)
  );

endmodule

// ===== rtl/core/ntc_front.sv =====
// Front end: accepts requests and scans the table for the matching segment.
// Depends on ntc_pkg; feeds ntc_queue.
module ntc_front #(
  parameter int TABLE_POINTS = 34
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [ntc_pkg::RES_W-1:0]        in_resistance_in,
  input  logic signed [ntc_pkg::TEMP_W-1:0] in_temperature_in,
  output logic                             push,
  output ntc_pkg::q_entry_t                push_data,
  input  logic                             full
);

  localparam int USED = (TABLE_POINTS > ntc_pkg::HELD_POINTS) ?
                        ntc_pkg::HELD_POINTS : TABLE_POINTS;
  localparam int LAST_SEG = (USED >= 2) ? USED - 2 : 0;
  localparam bit NO_SEGS  = (USED < 2);

  ntc_pkg::front_state_t state_r, state_nxt;
  logic                             kind_r, kind_nxt;
  logic                             miss_r, miss_nxt;
  ntc_pkg::idx_t                    seg_r, seg_nxt;
  logic [ntc_pkg::RES_W-1:0]        res_r, res_nxt;
  logic signed [ntc_pkg::TEMP_W-1:0] temp_r, temp_nxt;

  logic [ntc_pkg::RES_W-1:0]         ohm_lo, ohm_hi;
  logic signed [ntc_pkg::TEMP_W-1:0] centi_lo, centi_hi;
  logic                              hit;

  always_comb begin
    ohm_lo   = ntc_pkg::ntc_ohm(seg_r);
    ohm_hi   = ntc_pkg::ntc_ohm(ntc_pkg::idx_t'(seg_r + 1'b1));
    centi_lo = ntc_pkg::ntc_centi(seg_r);
    centi_hi = ntc_pkg::ntc_centi(ntc_pkg::idx_t'(seg_r + 1'b1));
    if (!kind_r) begin
      hit = (res_r <= ohm_lo) && (res_r >= ohm_hi);
    end else begin
      hit = (temp_r >= centi_lo) && (temp_r <= centi_hi);
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    miss_nxt  = miss_r;
    seg_nxt   = seg_r;
    res_nxt   = res_r;
    temp_nxt  = temp_r;
    push      = 1'b0;
    in_stall  = (state_r != ntc_pkg::F_IDLE);
    unique case (state_r)
      ntc_pkg::F_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          res_nxt   = in_resistance_in;
          temp_nxt  = in_temperature_in;
          seg_nxt   = '0;
          miss_nxt  = NO_SEGS;
          state_nxt = NO_SEGS ? ntc_pkg::F_PUSH : ntc_pkg::F_SCAN;
        end
      end
      ntc_pkg::F_SCAN: begin
        priority if (hit) begin
          miss_nxt  = 1'b0;
          state_nxt = ntc_pkg::F_PUSH;
        end else if (seg_r == ntc_pkg::idx_t'(LAST_SEG)) begin
          miss_nxt  = 1'b1;
          state_nxt = ntc_pkg::F_PUSH;
        end else begin
          seg_nxt = ntc_pkg::idx_t'(seg_r + 1'b1);
        end
      end
      ntc_pkg::F_PUSH: begin
        push = 1'b1;
        if (!full) begin
          state_nxt = ntc_pkg::F_IDLE;
        end
      end
      default: state_nxt = ntc_pkg::F_IDLE;
    endcase
  end

  assign push_data = '{kind: kind_r, miss: miss_r, seg: seg_r,
                       resistance: res_r, temperature: temp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntc_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    miss_r <= miss_nxt;
    seg_r  <= seg_nxt;
    res_r  <= res_nxt;
    temp_r <= temp_nxt;
  end

endmodule

// ===== rtl/core/ntc_queue.sv =====
// Two-entry request queue between the segment search and the interpolator.
// Depends on ntc_pkg.
`include "ntc_table_interpolator_core_assert.svh"

module ntc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ntc_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output ntc_pkg::q_entry_t pop_data,
  output logic              empty
);

  ntc_pkg::q_entry_t               entries_r [ntc_pkg::QUEUE_DEPTH];
  logic [ntc_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [ntc_pkg::QCNT_W-1:0]      count_r;
  logic                            do_push, do_pop;

  assign full     = (count_r == ntc_pkg::QCNT_W'(ntc_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  `NTC_ASSERT_IMP(a_count_bound, 1'b1, count_r <= ntc_pkg::QCNT_W'(ntc_pkg::QUEUE_DEPTH))
  `NTC_ASSERT_IMP(a_no_pop_empty, pop, !empty)

endmodule

// ===== rtl/core/ntc_back.sv =====
// Back end: interpolates within the chosen segment with a shared multiplier
// and a bit-serial divider, then holds the result. Depends on ntc_pkg.
`include "ntc_table_interpolator_core_assert.svh"

module ntc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              empty,
  input  ntc_pkg::q_entry_t                 pop_data,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ntc_pkg::TEMP_W-1:0] out_temperature_out,
  output logic [ntc_pkg::RES_W-1:0]         out_resistance_out,
  output logic                              out_status
);

  localparam int RES_W  = ntc_pkg::RES_W;
  localparam int TEMP_W = ntc_pkg::TEMP_W;
  localparam int SPAN_W = ntc_pkg::SPAN_W;
  localparam int DIV_W  = ntc_pkg::DIV_W;
  localparam int CNT_W  = ntc_pkg::CNT_W;

  ntc_pkg::back_state_t state_r, state_nxt;
  logic                     kind_r, kind_nxt;
  logic                     miss_r, miss_nxt;
  logic [RES_W-1:0]         rlo_r, rlo_nxt;
  logic [RES_W-1:0]         rhi_r, rhi_nxt;
  logic signed [TEMP_W-1:0] tlo_r, tlo_nxt;
  logic [RES_W-1:0]         res_r, res_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic [DIV_W-1:0]         prod_r, prod_nxt;
  logic [DIV_W-1:0]         quo_r, quo_nxt;
  logic [SPAN_W-1:0]        rem_r, rem_nxt;
  logic [SPAN_W-1:0]        divisor_r, divisor_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic [RES_W-1:0]         out_res_r, out_res_nxt;
  logic                     out_status_r, out_status_nxt;

  logic [RES_W-1:0]           ohm_diff, seg_ohms;
  logic signed [TEMP_W:0]     temp_diff;
  logic [RES_W-1:0]           mul_a;
  logic [SPAN_W-1:0]          mul_b;
  logic [RES_W+SPAN_W-1:0]    mul_full;
  logic [DIV_W-1:0]           base_ohms;
  logic [SPAN_W:0]            shifted, trial;
  logic                       round_up;
  logic signed [TEMP_W-1:0]   temp_res;

  always_comb begin
    ohm_diff  = rlo_r - res_r;
    seg_ohms  = rlo_r - rhi_r;
    temp_diff = temp_r - tlo_r;
    mul_a     = kind_r ? RES_W'(temp_diff[8:0]) : ohm_diff;
    mul_b     = kind_r ? seg_ohms[SPAN_W-1:0] : SPAN_W'(ntc_pkg::SEG_SPAN);
    mul_full  = mul_a * mul_b;
    base_ohms = DIV_W'(rlo_r) * DIV_W'(ntc_pkg::SEG_SPAN);
    shifted   = {rem_r, quo_r[DIV_W-1]};
    trial     = shifted - {1'b0, divisor_r};
    // Negative segment base: truncation toward zero rounds the fraction up.
    round_up  = tlo_r[TEMP_W-1] && (rem_r != '0);
    temp_res  = tlo_r + $signed({6'b0, quo_r[9:0]}) + $signed({15'b0, round_up});
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    miss_nxt       = miss_r;
    rlo_nxt        = rlo_r;
    rhi_nxt        = rhi_r;
    tlo_nxt        = tlo_r;
    res_nxt        = res_r;
    temp_nxt       = temp_r;
    prod_nxt       = prod_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    divisor_nxt    = divisor_r;
    cnt_nxt        = cnt_r;
    out_temp_nxt   = out_temp_r;
    out_res_nxt    = out_res_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pop            = 1'b0;
    unique case (state_r)
      ntc_pkg::B_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          kind_nxt  = pop_data.kind;
          miss_nxt  = pop_data.miss;
          res_nxt   = pop_data.resistance;
          temp_nxt  = pop_data.temperature;
          rlo_nxt   = ntc_pkg::ntc_ohm(pop_data.seg);
          rhi_nxt   = ntc_pkg::ntc_ohm(ntc_pkg::idx_t'(pop_data.seg + 1'b1));
          tlo_nxt   = ntc_pkg::ntc_centi(pop_data.seg);
          state_nxt = pop_data.miss ? ntc_pkg::B_OUT : ntc_pkg::B_MUL;
        end
      end
      ntc_pkg::B_MUL: begin
        prod_nxt  = mul_full[DIV_W-1:0];
        state_nxt = ntc_pkg::B_PREP;
      end
      ntc_pkg::B_PREP: begin
        if (kind_r) begin
          quo_nxt     = base_ohms - prod_r;
          divisor_nxt = SPAN_W'(ntc_pkg::SEG_SPAN);
        end else begin
          quo_nxt     = prod_r;
          divisor_nxt = seg_ohms[SPAN_W-1:0];
        end
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(DIV_W - 1);
        state_nxt = ntc_pkg::B_DIV;
      end
      ntc_pkg::B_DIV: begin
        // One restoring step per cycle, dividend shifts out as quotient shifts in.
        if (!trial[SPAN_W]) begin
          rem_nxt = trial[SPAN_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[SPAN_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ntc_pkg::B_OUT;
        end
      end
      ntc_pkg::B_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (miss_r) begin
            out_temp_nxt   = '0;
            out_res_nxt    = '0;
            out_status_nxt = 1'b1;
          end else if (kind_r) begin
            out_temp_nxt   = '0;
            out_res_nxt    = quo_r[RES_W-1:0];
            out_status_nxt = 1'b0;
          end else begin
            out_temp_nxt   = temp_res;
            out_res_nxt    = '0;
            out_status_nxt = 1'b0;
          end
          state_nxt = ntc_pkg::B_IDLE;
        end
      end
      default: state_nxt = ntc_pkg::B_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_temperature_out = out_temp_r;
  assign out_resistance_out  = out_res_r;
  assign out_status          = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ntc_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    miss_r       <= miss_nxt;
    rlo_r        <= rlo_nxt;
    rhi_r        <= rhi_nxt;
    tlo_r        <= tlo_nxt;
    res_r        <= res_nxt;
    temp_r       <= temp_nxt;
    prod_r       <= prod_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    divisor_r    <= divisor_nxt;
    cnt_r        <= cnt_nxt;
    out_temp_r   <= out_temp_nxt;
    out_res_r    <= out_res_nxt;
    out_status_r <= out_status_nxt;
  end

  `NTC_ASSERT_IMP(a_miss_zero, out_valid_r && out_status_r,
                  out_temp_r == '0 && out_res_r == '0)
  `NTC_ASSERT_IMP(a_div_nonzero, state_r == ntc_pkg::B_DIV, divisor_r != '0)
  `NTC_ASSERT_NXT(a_div_done, state_r == ntc_pkg::B_DIV && cnt_r == '0,
                  state_r == ntc_pkg::B_OUT)

endmodule

// ===== verif/tb_ntc_table_interpolator_core.sv =====
// Self-checking testbench for ntc_table_interpolator_core.
// Predicts each thermistor conversion from its own copy of the table and checks the
// results in order; needs only ntc_pkg and the core RTL.
module tb_ntc_table_interpolator_core;

  localparam int  USED_POINTS   = 34;
  localparam int  HELD_POINTS   = 34;
  localparam int  CENTI_PER_DEG = 100;
  localparam int  CYCLE_LIMIT   = 1_000_000;
  localparam int  HOLD_CYCLES   = 600;
  localparam int  SETTLE_CYCLES = 150;
  localparam int  PRINT_LIMIT   = 40;

  localparam logic KIND_OHMS_TO_CENTI = 1'b0;
  localparam logic KIND_CENTI_TO_OHMS = 1'b1;
  localparam logic ST_OK              = 1'b0;
  localparam logic ST_OUTSIDE         = 1'b1;

  typedef struct {
    logic signed [ntc_pkg::TEMP_W-1:0] temperature;
    logic [ntc_pkg::RES_W-1:0]         resistance;
    logic                              status;
  } reading_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_kind = 1'b0;
  logic [ntc_pkg::RES_W-1:0]         in_resistance_in = '0;
  logic signed [ntc_pkg::TEMP_W-1:0] in_temperature_in = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [ntc_pkg::TEMP_W-1:0] out_temperature_out;
  logic [ntc_pkg::RES_W-1:0]         out_resistance_out;
  logic                              out_status;

  reading_t expected_readings[$];
  reading_t want;
  int       fail_count = 0;
  int       cycle_count = 0;
  int       in_idle_pct = 0;
  int       out_idle_pct = 0;
  int       hold_requests = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  ntc_table_interpolator_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_resistance_in    (in_resistance_in),
    .in_temperature_in   (in_temperature_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_temperature_out (out_temperature_out),
    .out_resistance_out  (out_resistance_out),
    .out_status          (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint ohms_at_point(int idx);
    int pts [0:HELD_POINTS-1];
    pts = '{195652, 148171, 113347, 87559, 68237, 53650, 42506, 33892,
            27219, 22021, 17926, 14674, 12081, 10000, 8315, 6948,
            5834, 4917, 4161, 3535, 3014, 2586, 2228, 1925,
            1669, 1452, 1268, 1110, 974, 858, 758, 672,
            596, 531};
    return longint'(pts[idx]);
  endfunction

  function automatic longint degrees_at_point(int idx);
    return longint'(-40 + 5 * idx);
  endfunction

  // First segment whose inclusive bounds hold the value wins; exact result,
  // truncated toward zero.
  function automatic reading_t interpolate_reading(logic kind,
                                                   logic [ntc_pkg::RES_W-1:0] ohms,
                                                   logic signed [ntc_pkg::TEMP_W-1:0] centi);
    reading_t res;
    longint   ohm_val, centi_val, r_lo, r_hi, t_lo, t_hi, span, acc;
    int       npts, i;
    res.temperature = '0;
    res.resistance  = '0;
    res.status      = ST_OUTSIDE;
    ohm_val   = longint'(ohms);
    centi_val = longint'(centi);
    npts = (USED_POINTS > HELD_POINTS) ? HELD_POINTS : USED_POINTS;
    for (i = 0; i + 1 < npts; i++) begin
      if (res.status == ST_OUTSIDE) begin
        r_lo = ohms_at_point(i);
        r_hi = ohms_at_point(i + 1);
        t_lo = degrees_at_point(i) * CENTI_PER_DEG;
        t_hi = degrees_at_point(i + 1) * CENTI_PER_DEG;
        if (kind == KIND_OHMS_TO_CENTI) begin
          span = r_lo - r_hi;
          if (ohm_val <= r_lo && ohm_val >= r_hi && span != 0) begin
            acc = (t_lo * span + (r_lo - ohm_val) * (t_hi - t_lo)) / span;
            res.temperature = acc[ntc_pkg::TEMP_W-1:0];
            res.status      = ST_OK;
          end
        end else begin
          span = t_hi - t_lo;
          if (centi_val >= t_lo && centi_val <= t_hi && span != 0) begin
            acc = (r_lo * span + (centi_val - t_lo) * (r_hi - r_lo)) / span;
            res.resistance = acc[ntc_pkg::RES_W-1:0];
            res.status     = ST_OK;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // Predict on each accepted request, compare each accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_readings.push_back(interpolate_reading(in_kind, in_resistance_in,
                                                        in_temperature_in));
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_readings.pop_front();
          if (out_temperature_out !== want.temperature)
            report_mismatch($sformatf("temperature_out %0d, expected %0d",
                                      out_temperature_out, want.temperature));
          if (out_resistance_out !== want.resistance)
            report_mismatch($sformatf("resistance_out %0d, expected %0d",
                                      out_resistance_out, want.resistance));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0b, expected %0b", out_status, want.status));
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  task automatic send_request(logic kind, logic [ntc_pkg::RES_W-1:0] ohms,
                              logic signed [ntc_pkg::TEMP_W-1:0] centi);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    // Now and then a long gap, so the pause lands mid-search or mid-divide.
    if (in_idle_pct != 0 && $urandom_range(19) == 0) gap += $urandom_range(80, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_resistance_in  <= ohms;
    in_temperature_in <= centi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_reading();
    logic                              kind;
    logic [ntc_pkg::RES_W-1:0]         ohms;
    logic signed [ntc_pkg::TEMP_W-1:0] centi;
    int                                pick, idx;
    kind  = logic'($urandom_range(1));
    ohms  = ntc_pkg::RES_W'($urandom);
    centi = ntc_pkg::TEMP_W'($urandom);
    pick  = $urandom_range(99);
    idx   = $urandom_range(HELD_POINTS - 1);
    if (kind == KIND_OHMS_TO_CENTI) begin
      if (pick < 60)
        ohms = ntc_pkg::RES_W'($urandom_range(195652, 531));
      else if (pick < 80)
        ohms = ntc_pkg::RES_W'(ohms_at_point(idx) + longint'($urandom_range(4)) - 2);
      else if (pick < 90)
        ohms = ntc_pkg::RES_W'($urandom_range(262143, 195653));
      else if (pick < 95)
        ohms = ntc_pkg::RES_W'($urandom_range(530));
    end else begin
      if (pick < 60)
        centi = ntc_pkg::TEMP_W'(int'($urandom_range(16500)) - 4000);
      else if (pick < 80)
        centi = ntc_pkg::TEMP_W'(degrees_at_point(idx) * CENTI_PER_DEG
                                 + longint'($urandom_range(4)) - 2);
      else if (pick < 90)
        centi = ntc_pkg::TEMP_W'(int'($urandom_range(20266)) + 12501);
      else if (pick < 95)
        centi = ntc_pkg::TEMP_W'(-4001 - int'($urandom_range(28767)));
    end
    send_request(kind, ohms, centi);
  endtask

  // Hold the input low until every outstanding request has answered.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic run_table_edges();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_request(KIND_OHMS_TO_CENTI, 18'd195652, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd531, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd10000, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd10001, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd9999, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd150000, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd1000, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), -16'sd4000);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), 16'sd12500);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), 16'sd2500);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), 16'sd0);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), -16'sd1);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), -16'sd3999);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), 16'sd1234);
    drain_results();
  endtask

  task automatic run_outside_table();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_request(KIND_OHMS_TO_CENTI, 18'd195653, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd262143, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd0, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_OHMS_TO_CENTI, 18'd530, ntc_pkg::TEMP_W'($urandom));
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), -16'sd4001);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), 16'sd12501);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), 16'sd32767);
    send_request(KIND_CENTI_TO_OHMS, ntc_pkg::RES_W'($urandom), -16'sd32768);
    drain_results();
  endtask

  task automatic run_random_readings(int count, int send_pct, int recv_pct);
    in_idle_pct  = send_pct;
    out_idle_pct = recv_pct;
    repeat (count) send_random_reading();
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering: the queue fills and
  // the input must stall.
  task automatic run_output_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_requests++;
    repeat (12) send_random_reading();
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_table_edges();
    run_outside_table();
    run_random_readings(500, 24, 51);
    run_random_readings(500, 51, 24);
    run_output_backpressure();
    run_random_readings(530, 0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
